>>> hdl/rgbls_pkg.sv
package rgbls_pkg;

  localparam int MATRIX_ROWS    = 8;
  localparam int MATRIX_COLUMNS = 8;
  localparam int STORE_DEPTH    = MATRIX_ROWS * MATRIX_COLUMNS;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int ROW_W          = $clog2(MATRIX_ROWS);
  localparam int COL_W          = $clog2(MATRIX_COLUMNS);
  localparam int WORD_BITS      = 24;
  localparam int POS_W          = 5;

  // request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // colour codes
  localparam logic [2:0] COLOR_OFF   = 3'd0;
  localparam logic [2:0] COLOR_RED   = 3'd1;
  localparam logic [2:0] COLOR_GREEN = 3'd2;
  localparam logic [2:0] COLOR_BLUE  = 3'd3;
  localparam logic [2:0] COLOR_RG    = 3'd4;
  localparam logic [2:0] COLOR_GB    = 3'd5;
  localparam logic [2:0] COLOR_BR    = 3'd6;
  localparam logic [2:0] COLOR_ALL   = 3'd7;

  localparam logic [2:0] COLOR_RESET = COLOR_GB;

  localparam logic [WORD_BITS-1:0] RED_MASK [MATRIX_COLUMNS] = '{
    24'h000001, 24'h040000, 24'h000008, 24'h200000,
    24'h000040, 24'h010000, 24'h000200, 24'h002000
  };
  localparam logic [WORD_BITS-1:0] GREEN_MASK [MATRIX_COLUMNS] = '{
    24'h800000, 24'h000004, 24'h100000, 24'h000020,
    24'h000080, 24'h008000, 24'h000400, 24'h004000
  };
  localparam logic [WORD_BITS-1:0] BLUE_MASK [MATRIX_COLUMNS] = '{
    24'h000002, 24'h080000, 24'h000010, 24'h400000,
    24'h020000, 24'h000100, 24'h001000, 24'h000800
  };

  // datapath commands from the controller
  typedef struct packed {
    logic             wr_en;
    logic             row_adv;
    logic             rd_en;
    logic [COL_W-1:0] rd_col;
    logic             acc_en;
    logic             shift_en;
  } dp_cmd_t;

  // column contribution of one pixel
  function automatic logic [WORD_BITS-1:0] col_mask(input logic [COL_W-1:0] col,
                                                    input logic [2:0]       color);
    logic r;
    logic g;
    logic b;
    r = 1'b0;
    g = 1'b0;
    b = 1'b0;
    unique case (color) inside
      COLOR_OFF:                                    ;
      COLOR_RED:                                    r = 1'b1;
      COLOR_GREEN:                                  g = 1'b1;
      COLOR_BLUE:                                   b = 1'b1;
      COLOR_RG:                                     begin r = 1'b1; g = 1'b1; end
      COLOR_GB:                                     begin g = 1'b1; b = 1'b1; end
      COLOR_BR:                                     begin b = 1'b1; r = 1'b1; end
      COLOR_ALL:                                    begin r = 1'b1; g = 1'b1; b = 1'b1; end
      default:                                      ;
    endcase
    return ({WORD_BITS{r}} & RED_MASK[col]) |
           ({WORD_BITS{g}} & GREEN_MASK[col]) |
           ({WORD_BITS{b}} & BLUE_MASK[col]);
  endfunction

endpackage

>>> hdl/rgbls_dp.sv
module rgbls_dp
  import rgbls_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [2:0]           wr_color,
  output logic                 serial_bit,
  output logic [MATRIX_ROWS-1:0] row_select
);

  logic [2:0]           mem_r [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid_r;
  logic [ROW_W-1:0]     row_r;
  logic [ADDR_W-1:0]    rd_addr;
  logic [2:0]           rd_data_r;
  logic                 rd_valid_r;
  logic [COL_W-1:0]     rd_col_r;
  logic [2:0]           pix_color;
  logic [WORD_BITS-1:0] word_r;
  logic [WORD_BITS-1:0] word_nxt;

  assign rd_addr = {row_r, cmd.rd_col};

  // frame store, no reset on the array itself
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_color;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_col_r  <= cmd.rd_col;
    end
  end

  // written marks; unwritten entries read as the reset colour
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else if (cmd.row_adv) begin
      row_r <= row_r + ROW_W'(1);
    end
  end

  assign pix_color = rd_valid_r ? rd_data_r : COLOR_RESET;

  always_comb begin
    word_nxt = word_r;
    if (cmd.row_adv) begin
      word_nxt = '0;
    end else if (cmd.acc_en) begin
      word_nxt = word_r | col_mask(rd_col_r, pix_color);
    end else if (cmd.shift_en) begin
      word_nxt = word_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign serial_bit = word_r[0];

  always_comb begin
    row_select        = '0;
    row_select[row_r] = 1'b1;
  end

endmodule

>>> hdl/rgbls_ctrl.sv
module rgbls_ctrl
  import rgbls_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             req_type,
  output logic             busy,
  output dp_cmd_t          cmd,
  output logic             out_valid,
  output logic [POS_W-1:0] bit_position,
  output logic             latch_now
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_READ  = 3'b010,
    S_SHIFT = 3'b100
  } state_t;

  localparam logic [POS_W-1:0] READ_LAST  = POS_W'(MATRIX_COLUMNS);
  localparam logic [POS_W-1:0] SHIFT_LAST = POS_W'(WORD_BITS - 1);

  state_t           state_r;
  state_t           state_nxt;
  logic [POS_W-1:0] cnt_r;
  logic [POS_W-1:0] cnt_nxt;

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    out_valid    = 1'b0;
    latch_now    = 1'b0;
    bit_position = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.wr_en = start && (req_type == REQ_WRITE);
        if (start && (req_type == REQ_TICK)) begin
          cmd.row_adv = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        // issue column reads, fold in the previous one
        cmd.rd_en  = (cnt_r < READ_LAST);
        cmd.rd_col = cnt_r[COL_W-1:0];
        cmd.acc_en = (cnt_r != '0);
        if (cnt_r == READ_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_SHIFT;
        end else begin
          cnt_nxt = cnt_r + POS_W'(1);
        end
      end
      S_SHIFT: begin
        out_valid    = 1'b1;
        cmd.shift_en = 1'b1;
        latch_now    = (cnt_r == SHIFT_LAST);
        if (cnt_r == SHIFT_LAST) begin
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + POS_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> hdl/rgb_led_matrix_row_scanner.sv
// RGB LED matrix row scanner. A beat on the input side is taken at a clock edge with start
// high and busy low. A pixel write (in_req_type 0) lands in the 64-entry frame store at that
// edge; busy stays low, so writes go back to back at one per cycle. A scan tick
// (in_req_type 1) advances the row and raises busy: a gather phase reads the row's 8 pixels
// from the frame store (one read a cycle through its single registered read port), then the
// 24-bit column word goes out bit 0 first, one beat per cycle, each marked by out_valid. The
// receiver cannot stall: every beat shows for exactly one cycle. The next input beat can be
// taken in the cycle after the latch bit. out_row_select is the one-hot of the row just
// scanned; out_latch_now marks bit 23. The first tick after reset scans row 1. Every pixel
// reads as green+blue until written; no clearing pass is needed.
module rgb_led_matrix_row_scanner
  import rgbls_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   start,
  output logic                   busy,
  input  logic                   in_req_type,
  input  logic [ADDR_W-1:0]      in_pixel_index,
  input  logic [2:0]             in_pixel_color,
  // result channel
  output logic                   out_valid,
  output logic                   out_serial_bit,
  output logic [POS_W-1:0]       out_bit_position,
  output logic [MATRIX_ROWS-1:0] out_row_select,
  output logic                   out_latch_now
);

  dp_cmd_t cmd;

  // sequencing: idle / gather / shift out
  rgbls_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .req_type     (in_req_type),
    .busy         (busy),
    .cmd          (cmd),
    .out_valid    (out_valid),
    .bit_position (out_bit_position),
    .latch_now    (out_latch_now)
  );

  // frame store, row counter and column word shifter
  rgbls_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_addr    (in_pixel_index),
    .wr_color   (in_pixel_color),
    .serial_bit (out_serial_bit),
    .row_select (out_row_select)
  );

  // a result beat only ever appears while a tick is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // the latch bit closes the tick
  a_latch_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_latch_now) |=> !busy && !out_valid)
    else $error("tick did not finish after latch bit");

  // an accepted tick gathers pixels before any bit goes out
  a_tick_gather: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type) |=> busy && !out_valid)
    else $error("tick not started correctly");

  // the row drive is one-hot on every beat
  a_row_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot(out_row_select))
    else $error("row select not one-hot");

  // bits come in order
  a_bit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_latch_now) |=> out_valid &&
      (out_bit_position == $past(out_bit_position) + 5'd1))
    else $error("bit position out of order");

endmodule
